@@ src/h264_sps_pkg.sv @@
// ----------------------------------------------------------------------------
// h264_sps_pkg
// Shared types and constants of the SPS header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package h264_sps_pkg;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_DONE = 2'd1,
    RES_BAD  = 2'd2,
    RES_LONG = 2'd3
  } res_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_TRUNC = 2'd1;
  localparam logic [1:0] STATUS_LONG  = 2'd2;

  localparam int PocCntW  = 9;
  localparam int ZeroCntW = 6;
  localparam int TdataOutW = 104;

  // profiles that carry the high profile extension fields
  localparam logic [7:0] PROF_HIGH     = 8'd100;
  localparam logic [7:0] PROF_HIGH10   = 8'd110;
  localparam logic [7:0] PROF_HIGH422  = 8'd122;
  localparam logic [7:0] PROF_HIGH444  = 8'd244;
  localparam logic [7:0] PROF_CAVLC444 = 8'd44;
  localparam logic [7:0] PROF_SVC_B    = 8'd83;
  localparam logic [7:0] PROF_SVC_H    = 8'd86;
  localparam logic [7:0] PROF_MVC_H    = 8'd118;
  localparam logic [7:0] PROF_STEREO   = 8'd128;
  localparam logic [7:0] PROF_MFC_H    = 8'd134;
  localparam logic [7:0] PROF_MFC_D    = 8'd135;
  localparam logic [7:0] PROF_MVCD     = 8'd138;
  localparam logic [7:0] PROF_MVCD_E   = 8'd139;

  typedef struct packed {
    logic       load_byte;
    logic       step;
    logic       clear_unit;
    logic       fix_group;
    logic       load_out;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    res_t res;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/h264_sps_ctrl.sv @@
// ----------------------------------------------------------------------------
// h264_sps_ctrl
// Controller: byte handshake, bit sequencing, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_sps_ctrl
  import h264_sps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     in_tlast,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIX,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic       last_r, last_nxt;
  logic       finished_r, finished_nxt;
  logic       ovalid_r, ovalid_nxt;
  res_t       res_r, res_nxt;
  res_t       res_fin;
  logic       in_acc;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !ovalid_r || out_tready;

  always_comb begin
    if (stat.res != RES_NONE) begin
      res_fin = stat.res;
    end else if (last_r) begin
      res_fin = RES_BAD;
    end else begin
      res_fin = RES_NONE;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    bit_cnt_nxt  = bit_cnt_r;
    last_nxt     = last_r;
    finished_nxt = finished_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    res_nxt      = res_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (finished_r) begin
            // swallow trailing bytes of the unit
            if (in_tlast) begin
              cmd.clear_unit = 1'b1;
              finished_nxt   = 1'b0;
            end
          end else begin
            cmd.load_byte = 1'b1;
            last_nxt      = in_tlast;
            bit_cnt_nxt   = '0;
            state_nxt     = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd.step    = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (stat.res != RES_NONE || bit_cnt_r == 3'd7) begin
          res_nxt   = res_fin;
          state_nxt = (res_fin == RES_NONE) ? S_IDLE : S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix_group = (res_r == RES_BAD);
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          ovalid_nxt   = 1'b1;
          if (last_r) begin
            cmd.clear_unit = 1'b1;
          end else begin
            finished_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    unique case (res_r)
      RES_DONE: cmd.status = STATUS_OK;
      RES_LONG: cmd.status = STATUS_LONG;
      default:  cmd.status = STATUS_TRUNC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      bit_cnt_r  <= '0;
      last_r     <= 1'b0;
      finished_r <= 1'b0;
      ovalid_r   <= 1'b0;
      res_r      <= RES_NONE;
    end else begin
      state_r    <= state_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      last_r     <= last_nxt;
      finished_r <= finished_nxt;
      ovalid_r   <= ovalid_nxt;
      res_r      <= res_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/h264_sps_dp.sv @@
// ----------------------------------------------------------------------------
// h264_sps_dp
// Datapath: bit shifter, Exp-Golomb decoder, parse phase, fields, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_sps_dp
  import h264_sps_pkg::*;
#(
  parameter int MAX_POC_CYCLE    = 256,
  parameter int MAX_GOLOMB_ZEROS = 31
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] byte_in,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        stat,
  output logic [TdataOutW-1:0] out_data
);

  typedef enum logic [4:0] {
    PH_NALHDR, PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_SPSID, PH_CHROMA, PH_SEPCOL,
    PH_BDLUMA, PH_BDCHROMA, PH_QPBYPASS, PH_SMFLAG, PH_SLFLAG, PH_SLDELTA,
    PH_LOG2FN, PH_POCTYPE, PH_POCLSB, PH_DELTAZERO, PH_OFFNONREF, PH_OFFTB,
    PH_NCYCLE, PH_OFFREF, PH_MAXREF, PH_GAPS, PH_WIDTH, PH_HEIGHT, PH_FRAMEMBS
  } phase_t;

  localparam logic [ZeroCntW-1:0] MaxZeros = ZeroCntW'(MAX_GOLOMB_ZEROS);
  localparam logic [32:0]         MaxCycle = 33'(MAX_POC_CYCLE);

  logic [7:0]          shift_r, shift_nxt;
  phase_t              phase_r, phase_nxt;
  logic [ZeroCntW-1:0] zc_r, zc_nxt;
  logic [32:0]         gv_r, gv_nxt;
  logic                suf_r, suf_nxt;
  logic [3:0]          sl_idx_r, sl_idx_nxt;
  logic [6:0]          sl_ent_r, sl_ent_nxt;
  logic [7:0]          last_scale_r, last_scale_nxt;
  logic [PocCntW-1:0]  poc_cnt_r, poc_cnt_nxt;

  logic [7:0]  profile_r, profile_nxt, sps_id_r, sps_id_nxt;
  logic [7:0]  chroma_r, chroma_nxt, bdl_r, bdl_nxt, maxref_r, maxref_nxt;
  logic        chroma3_r, chroma3_nxt, fmo_r, fmo_nxt;
  logic [8:0]  log2fn_r, log2fn_nxt, poctype_r, poctype_nxt, poclsb_r, poclsb_nxt;
  logic [15:0] width_r, width_nxt, height_r, height_nxt;

  logic [TdataOutW-1:0] out_r;

  // golomb bit step
  logic        bit_in;
  logic        g_done, g_bad;
  logic [32:0] g_val, g_shift;
  logic [ZeroCntW-1:0] g_zc_dec;
  logic [8:0]  v_p1;
  logic [7:0]  delta, nscale;
  logic [6:0]  ent_inc, sl_size;
  logic [3:0]  idx_inc, lists;
  res_t        res;

  function automatic logic [7:0] sat8(input logic [32:0] v);
    sat8 = (v > 33'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [32:0] v);
    sat16 = (v > 33'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic is_high(input logic [7:0] p);
    case (p)
      PROF_HIGH, PROF_HIGH10, PROF_HIGH422, PROF_HIGH444, PROF_CAVLC444,
      PROF_SVC_B, PROF_SVC_H, PROF_MVC_H, PROF_STEREO, PROF_MFC_H, PROF_MFC_D,
      PROF_MVCD, PROF_MVCD_E: is_high = 1'b1;
      default: is_high = 1'b0;
    endcase
  endfunction

  assign bit_in   = shift_r[7];
  assign g_shift  = {gv_r[31:0], bit_in};
  assign g_zc_dec = zc_r - ZeroCntW'(1);
  assign stat.res = res;
  assign out_data = out_r;

  always_comb begin
    g_done = 1'b0;
    g_bad  = 1'b0;
    g_val  = '0;
    if (!suf_r) begin
      if (!bit_in) begin
        g_bad = (zc_r + ZeroCntW'(1)) > MaxZeros;
      end else if (zc_r == '0) begin
        g_done = 1'b1;
      end
    end else if (g_zc_dec == '0) begin
      g_done = 1'b1;
      g_val  = g_shift - 33'd1;
    end
  end

  always_comb begin
    v_p1    = g_val[8:0] + 9'd1;
    delta   = g_val[0] ? v_p1[8:1] : 8'(8'd0 - g_val[8:1]);
    nscale  = last_scale_r + delta;
    ent_inc = sl_ent_r + 7'd1;
    sl_size = (sl_idx_r < 4'd6) ? 7'd16 : 7'd64;
    idx_inc = sl_idx_r + 4'd1;
    lists   = chroma3_r ? 4'd12 : 4'd8;
  end

  always_comb begin
    shift_nxt      = shift_r;
    phase_nxt      = phase_r;
    zc_nxt         = zc_r;
    gv_nxt         = gv_r;
    suf_nxt        = suf_r;
    sl_idx_nxt     = sl_idx_r;
    sl_ent_nxt     = sl_ent_r;
    last_scale_nxt = last_scale_r;
    poc_cnt_nxt    = poc_cnt_r;
    profile_nxt    = profile_r;
    sps_id_nxt     = sps_id_r;
    chroma_nxt     = chroma_r;
    chroma3_nxt    = chroma3_r;
    bdl_nxt        = bdl_r;
    log2fn_nxt     = log2fn_r;
    poctype_nxt    = poctype_r;
    poclsb_nxt     = poclsb_r;
    maxref_nxt     = maxref_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    fmo_nxt        = fmo_r;
    res            = RES_NONE;

    if (cmd.load_byte) begin
      shift_nxt = byte_in;
    end

    if (cmd.step) begin
      shift_nxt = {shift_r[6:0], 1'b0};
      unique case (phase_r)
        PH_NALHDR, PH_PROFILE, PH_CONSTR, PH_LEVEL: begin
          gv_nxt = {25'd0, gv_r[6:0], bit_in};
          zc_nxt = zc_r + ZeroCntW'(1);
          if (zc_r == ZeroCntW'(7)) begin
            if (phase_r == PH_PROFILE) begin
              profile_nxt = {gv_r[6:0], bit_in};
            end
            gv_nxt    = '0;
            zc_nxt    = '0;
            phase_nxt = phase_t'(phase_r + 5'd1);
          end
        end
        PH_SEPCOL:    phase_nxt = PH_BDLUMA;
        PH_QPBYPASS:  phase_nxt = PH_SMFLAG;
        PH_DELTAZERO: phase_nxt = PH_OFFNONREF;
        PH_GAPS:      phase_nxt = PH_WIDTH;
        PH_SMFLAG: begin
          sl_idx_nxt = '0;
          phase_nxt  = bit_in ? PH_SLFLAG : PH_LOG2FN;
        end
        PH_SLFLAG: begin
          if (bit_in) begin
            sl_ent_nxt     = '0;
            last_scale_nxt = 8'd8;
            phase_nxt      = PH_SLDELTA;
          end else begin
            sl_idx_nxt = idx_inc;
            phase_nxt  = (idx_inc >= lists) ? PH_LOG2FN : PH_SLFLAG;
          end
        end
        PH_FRAMEMBS: begin
          fmo_nxt = bit_in;
          res     = RES_DONE;
        end
        default: begin
          // exp-golomb coded field
          if (!suf_r) begin
            if (!bit_in) begin
              zc_nxt = zc_r + ZeroCntW'(1);
            end else if (zc_r != '0) begin
              suf_nxt = 1'b1;
              gv_nxt  = 33'd1;
            end
          end else begin
            gv_nxt = g_shift;
            zc_nxt = g_zc_dec;
          end
          if (g_bad) begin
            res = RES_BAD;
          end else if (g_done) begin
            gv_nxt  = '0;
            zc_nxt  = '0;
            suf_nxt = 1'b0;
            case (phase_r)
              PH_SPSID: begin
                sps_id_nxt = sat8(g_val);
                phase_nxt  = is_high(profile_r) ? PH_CHROMA : PH_LOG2FN;
              end
              PH_CHROMA: begin
                chroma_nxt  = sat8(g_val);
                chroma3_nxt = (g_val == 33'd3);
                phase_nxt   = (g_val == 33'd3) ? PH_SEPCOL : PH_BDLUMA;
              end
              PH_BDLUMA: begin
                bdl_nxt   = (g_val >= 33'd247) ? 8'hFF : 8'(g_val[7:0] + 8'd8);
                phase_nxt = PH_BDCHROMA;
              end
              PH_BDCHROMA: phase_nxt = PH_QPBYPASS;
              PH_SLDELTA: begin
                if (nscale != 8'd0) begin
                  last_scale_nxt = nscale;
                end
                sl_ent_nxt = ent_inc;
                if (nscale == 8'd0 || ent_inc >= sl_size) begin
                  sl_idx_nxt = idx_inc;
                  phase_nxt  = (idx_inc >= lists) ? PH_LOG2FN : PH_SLFLAG;
                end
              end
              PH_LOG2FN: begin
                log2fn_nxt = {1'b0, sat8(g_val)};
                phase_nxt  = PH_POCTYPE;
              end
              PH_POCTYPE: begin
                poctype_nxt = {1'b0, sat8(g_val)};
                if (g_val == 33'd0) begin
                  phase_nxt = PH_POCLSB;
                end else if (g_val == 33'd1) begin
                  phase_nxt = PH_DELTAZERO;
                end else begin
                  phase_nxt = PH_MAXREF;
                end
              end
              PH_POCLSB: begin
                poclsb_nxt = {1'b0, sat8(g_val)};
                phase_nxt  = PH_MAXREF;
              end
              PH_OFFNONREF: phase_nxt = PH_OFFTB;
              PH_OFFTB:     phase_nxt = PH_NCYCLE;
              PH_NCYCLE: begin
                if (g_val > MaxCycle) begin
                  res = RES_LONG;
                end else begin
                  poc_cnt_nxt = g_val[PocCntW-1:0];
                  phase_nxt   = (g_val == 33'd0) ? PH_MAXREF : PH_OFFREF;
                end
              end
              PH_OFFREF: begin
                if (poc_cnt_r <= PocCntW'(1)) begin
                  poc_cnt_nxt = '0;
                  phase_nxt   = PH_MAXREF;
                end else begin
                  poc_cnt_nxt = poc_cnt_r - PocCntW'(1);
                end
              end
              PH_MAXREF: begin
                maxref_nxt = sat8(g_val);
                phase_nxt  = PH_GAPS;
              end
              PH_WIDTH: begin
                width_nxt = sat16(g_val);
                phase_nxt = PH_HEIGHT;
              end
              PH_HEIGHT: begin
                height_nxt = sat16(g_val);
                phase_nxt  = PH_FRAMEMBS;
              end
              default: phase_nxt = PH_NALHDR;
            endcase
          end
        end
      endcase
    end

    // truncated group falls back to its unknown defaults
    if (cmd.fix_group) begin
      if (phase_r <= PH_SPSID) begin
        profile_nxt = '0;
        sps_id_nxt  = '0;
      end else if (phase_r <= PH_SLDELTA) begin
        chroma_nxt  = 8'd1;
        bdl_nxt     = 8'd8;
        chroma3_nxt = 1'b0;
      end else if (phase_r == PH_LOG2FN) begin
        log2fn_nxt = '1;
      end else if (phase_r <= PH_OFFREF) begin
        poctype_nxt = '1;
        poclsb_nxt  = '1;
      end else if (phase_r <= PH_HEIGHT) begin
        maxref_nxt = '0;
        width_nxt  = '0;
        height_nxt = '0;
      end else begin
        fmo_nxt = 1'b1;
      end
    end

    if (cmd.clear_unit) begin
      phase_nxt      = PH_NALHDR;
      zc_nxt         = '0;
      gv_nxt         = '0;
      suf_nxt        = 1'b0;
      sl_idx_nxt     = '0;
      sl_ent_nxt     = '0;
      last_scale_nxt = 8'd8;
      poc_cnt_nxt    = '0;
      profile_nxt    = '0;
      sps_id_nxt     = '0;
      chroma_nxt     = 8'd1;
      chroma3_nxt    = 1'b0;
      bdl_nxt        = 8'd8;
      log2fn_nxt     = '1;
      poctype_nxt    = '1;
      poclsb_nxt     = '1;
      maxref_nxt     = '0;
      width_nxt      = '0;
      height_nxt     = '0;
      fmo_nxt        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NALHDR;
      zc_r         <= '0;
      gv_r         <= '0;
      suf_r        <= 1'b0;
      sl_idx_r     <= '0;
      sl_ent_r     <= '0;
      last_scale_r <= 8'd8;
      poc_cnt_r    <= '0;
      profile_r    <= '0;
      sps_id_r     <= '0;
      chroma_r     <= 8'd1;
      chroma3_r    <= 1'b0;
      bdl_r        <= 8'd8;
      log2fn_r     <= '1;
      poctype_r    <= '1;
      poclsb_r     <= '1;
      maxref_r     <= '0;
      width_r      <= '0;
      height_r     <= '0;
      fmo_r        <= 1'b1;
    end else begin
      phase_r      <= phase_nxt;
      zc_r         <= zc_nxt;
      gv_r         <= gv_nxt;
      suf_r        <= suf_nxt;
      sl_idx_r     <= sl_idx_nxt;
      sl_ent_r     <= sl_ent_nxt;
      last_scale_r <= last_scale_nxt;
      poc_cnt_r    <= poc_cnt_nxt;
      profile_r    <= profile_nxt;
      sps_id_r     <= sps_id_nxt;
      chroma_r     <= chroma_nxt;
      chroma3_r    <= chroma3_nxt;
      bdl_r        <= bdl_nxt;
      log2fn_r     <= log2fn_nxt;
      poctype_r    <= poctype_nxt;
      poclsb_r     <= poclsb_nxt;
      maxref_r     <= maxref_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      fmo_r        <= fmo_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (cmd.load_out) begin
      out_r <= {2'b00, fmo_r, height_r, width_r, maxref_r, poclsb_r, poctype_r,
                log2fn_r, bdl_r, chroma_r, sps_id_r, profile_r, cmd.status};
    end
  end

endmodule

`default_nettype wire

@@ src/h264_sps_header_parser.sv @@
// ----------------------------------------------------------------------------
// h264_sps_header_parser
// Top level: H.264 sequence parameter set header parser.
// ----------------------------------------------------------------------------
// Feed the bytes of one SPS NAL unit (emulation-prevention bytes removed,
// header byte first, tlast on the final byte). The parser walks the bits MSB
// first, one bit per clock while it steps a byte: a byte is accepted in S_IDLE
// and stepped in S_RUN, ending early if the parse ends in it, and the next byte
// waits till then. The single result item passes S_FIX and S_OUT, held in S_OUT
// while the previous result item still waits in the output register, and then
// sits there while parsing goes on. One result item per unit; bytes after the
// parse end, up to tlast, are swallowed. Bit-serial Exp-Golomb sets the rate.
`default_nettype none

module h264_sps_header_parser
  import h264_sps_pkg::*;
#(
  parameter int MAX_POC_CYCLE    = 256,
  parameter int MAX_GOLOMB_ZEROS = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // nal_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], profile[9:2], sps_id[17:10], chroma_format[25:18],
  // bit_depth_luma[33:26], log2_max_frame_num_minus4[42:34], poc_type[51:43],
  // log2_max_poc_lsb_minus4[60:52], max_num_ref_frames[68:61],
  // pic_width_mbs_minus1[84:69], pic_height_units_minus1[100:85],
  // frame_mbs_only[101], zero fill above
  output logic [TdataOutW-1:0] out_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  h264_sps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  h264_sps_dp #(
    .MAX_POC_CYCLE    (MAX_POC_CYCLE),
    .MAX_GOLOMB_ZEROS (MAX_GOLOMB_ZEROS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_in  (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_tdata)
  );

endmodule

`default_nettype wire

@@ src/h264_sps_checker.sv @@
// ----------------------------------------------------------------------------
// h264_sps_checker
// Port-level checks of the SPS header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_sps_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata
);

  // output item holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad status code");

  a_bdl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:26] >= 8'd8)
    else $error("luma bit depth below 8");

  // poc lsb size is only known when poc type 0 was parsed
  a_poclsb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[60:52] != 9'h1FF |-> out_tdata[51:43] == 9'd0)
    else $error("poc lsb size without poc type 0");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind h264_sps_header_parser h264_sps_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ dv/tb_h264_sps_header_parser.sv @@
// ----------------------------------------------------------------------------
// tb_h264_sps_header_parser
// Self-checking testbench of the SPS header parser.
// ----------------------------------------------------------------------------
// Builds SPS NAL units bit by bit (well-formed, truncated, with bad codes and
// trailing junk), feeds them with random gaps and output stalls, predicts
// the result item of each unit in a bit-serial model and compares field by
// field.
`default_nettype none

module tb_h264_sps_header_parser;
  import h264_sps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 3000;
  localparam int MAX_GOLOMB_ZEROS_TB = 31;

  typedef enum int {
    ST_NALHDR, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SPSID, ST_CHROMA, ST_SEPCOL,
    ST_BDLUMA, ST_BDCHROMA, ST_QPBYPASS, ST_SMFLAG, ST_SLFLAG, ST_SLDELTA,
    ST_LOG2FN, ST_POCTYPE, ST_POCLSB, ST_DELTAZERO, ST_OFFNONREF, ST_OFFTB,
    ST_NCYCLE, ST_OFFREF, ST_MAXREF, ST_GAPS, ST_WIDTH, ST_HEIGHT, ST_FRAMEMBS
  } sps_phase_t;

  // msb first so that the struct lines up with out_tdata[101:0]
  typedef struct packed {
    logic        fmo;
    logic [15:0] height;
    logic [15:0] width;
    logic [7:0]  max_ref;
    logic [8:0]  poc_lsb;
    logic [8:0]  poc_type;
    logic [8:0]  log2fn;
    logic [7:0]  bd_luma;
    logic [7:0]  chroma;
    logic [7:0]  sps_id;
    logic [7:0]  profile;
    logic [1:0]  status;
  } sps_fields_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TdataOutW-1:0] out_tdata;

  int errors = 0;
  int bytes_sent = 0;
  bit rx_long_hold = 1'b0;
  bit stim_done = 1'b0;
  sps_fields_t sps_expected[$];

  h264_sps_header_parser i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- parser model ----------------
  sps_fields_t fld;
  logic chroma3;
  sps_phase_t phase;
  bit unit_done;
  int zcnt;
  longint unsigned gval;
  bit in_suffix;
  int list_idx, entry_idx;
  int last_sc, next_sc;
  longint unsigned poc_left;

  function automatic logic [15:0] clip(longint unsigned v, longint unsigned mx);
    return (v > mx) ? mx[15:0] : v[15:0];
  endfunction

  function automatic void group_reset(int g);
    case (g)
      0: begin fld.profile = 0; fld.sps_id = 0; end
      1: begin fld.chroma = 1; fld.bd_luma = 8; chroma3 = 0; end
      2: fld.log2fn = 9'h1FF;
      3: begin fld.poc_type = 9'h1FF; fld.poc_lsb = 9'h1FF; end
      4: begin fld.max_ref = 0; fld.width = 0; fld.height = 0; end
      default: fld.fmo = 1;
    endcase
  endfunction

  function automatic int group_at(sps_phase_t ph);
    if (ph <= ST_SPSID) return 0;
    if (ph <= ST_SLDELTA) return 1;
    if (ph == ST_LOG2FN) return 2;
    if (ph <= ST_OFFREF) return 3;
    if (ph <= ST_HEIGHT) return 4;
    return 5;
  endfunction

  function automatic void unit_clear();
    phase = ST_NALHDR; unit_done = 0; zcnt = 0; gval = 0; in_suffix = 0;
    list_idx = 0; entry_idx = 0; last_sc = 8; next_sc = 8; poc_left = 0;
    fld = '0;
    for (int g = 0; g < 6; g++) group_reset(g);
  endfunction

  // -1 bad code, 0 pending, 1 value ready
  function automatic int golomb_bit(bit b);
    if (!in_suffix) begin
      if (!b) begin
        zcnt++;
        return (zcnt > MAX_GOLOMB_ZEROS_TB) ? -1 : 0;
      end
      if (zcnt == 0) begin gval = 0; return 1; end
      in_suffix = 1; gval = 1;
      return 0;
    end
    gval = (gval << 1) | b;
    zcnt--;
    if (zcnt == 0) begin in_suffix = 0; gval = gval - 1; return 1; end
    return 0;
  endfunction

  function automatic void list_done();
    list_idx++;
    phase = (list_idx >= (chroma3 ? 12 : 8)) ? ST_LOG2FN : ST_SLFLAG;
  endfunction

  function automatic res_t bit_step(bit b);
    sps_phase_t ph;
    longint unsigned v;
    int r;
    int delta, size;
    ph = phase;
    case (ph)
      ST_NALHDR, ST_PROFILE, ST_CONSTR, ST_LEVEL: begin
        gval = ((gval << 1) | b) & 64'hFF;
        zcnt++;
        if (zcnt < 8) return RES_NONE;
        if (ph == ST_PROFILE) fld.profile = gval[7:0];
        gval = 0; zcnt = 0;
        phase = sps_phase_t'(ph + 1);
        return RES_NONE;
      end
      ST_SEPCOL: begin phase = ST_BDLUMA; return RES_NONE; end
      ST_QPBYPASS: begin phase = ST_SMFLAG; return RES_NONE; end
      ST_SMFLAG: begin
        list_idx = 0;
        phase = b ? ST_SLFLAG : ST_LOG2FN;
        return RES_NONE;
      end
      ST_SLFLAG: begin
        if (b) begin
          entry_idx = 0; last_sc = 8; next_sc = 8; phase = ST_SLDELTA;
        end else begin
          list_done();
        end
        return RES_NONE;
      end
      ST_DELTAZERO: begin phase = ST_OFFNONREF; return RES_NONE; end
      ST_GAPS: begin phase = ST_WIDTH; return RES_NONE; end
      ST_FRAMEMBS: begin fld.fmo = b; return RES_DONE; end
      default: ;
    endcase
    r = golomb_bit(b);
    if (r < 0) return RES_BAD;
    if (r == 0) return RES_NONE;
    v = gval; gval = 0; zcnt = 0;
    case (ph)
      ST_SPSID: begin
        fld.sps_id = 8'(clip(v, 255));
        phase = ST_LOG2FN;
        case (fld.profile)
          PROF_HIGH, PROF_HIGH10, PROF_HIGH422, PROF_HIGH444, PROF_CAVLC444,
          PROF_SVC_B, PROF_SVC_H, PROF_MVC_H, PROF_STEREO, PROF_MFC_H,
          PROF_MFC_D, PROF_MVCD, PROF_MVCD_E: phase = ST_CHROMA;
          default: ;
        endcase
      end
      ST_CHROMA: begin
        fld.chroma = 8'(clip(v, 255));
        chroma3 = (v == 3);
        phase = (v == 3) ? ST_SEPCOL : ST_BDLUMA;
      end
      ST_BDLUMA: begin
        fld.bd_luma = (v >= 247) ? 8'd255 : 8'(v + 8);
        phase = ST_BDCHROMA;
      end
      ST_BDCHROMA: phase = ST_QPBYPASS;
      ST_SLDELTA: begin
        delta = v[0] ? int'(((v + 1) >> 1) & 64'hFF) : int'((64'd0 - (v >> 1)) & 64'hFF);
        size = (list_idx < 6) ? 16 : 64;
        next_sc = (last_sc + delta) & 255;
        if (next_sc != 0) last_sc = next_sc;
        entry_idx++;
        if (next_sc == 0 || entry_idx >= size) list_done();
      end
      ST_LOG2FN: begin fld.log2fn = 9'(clip(v, 255)); phase = ST_POCTYPE; end
      ST_POCTYPE: begin
        fld.poc_type = 9'(clip(v, 255));
        phase = (v == 0) ? ST_POCLSB : ((v == 1) ? ST_DELTAZERO : ST_MAXREF);
      end
      ST_POCLSB: begin fld.poc_lsb = 9'(clip(v, 255)); phase = ST_MAXREF; end
      ST_OFFNONREF: phase = ST_OFFTB;
      ST_OFFTB: phase = ST_NCYCLE;
      ST_NCYCLE: begin
        if (v > 256) return RES_LONG;
        poc_left = v;
        phase = (v == 0) ? ST_MAXREF : ST_OFFREF;
      end
      ST_OFFREF: begin
        if (poc_left > 0) poc_left--;
        if (poc_left == 0) phase = ST_MAXREF;
      end
      ST_MAXREF: begin fld.max_ref = 8'(clip(v, 255)); phase = ST_GAPS; end
      ST_WIDTH: begin fld.width = clip(v, 65535); phase = ST_HEIGHT; end
      ST_HEIGHT: begin fld.height = clip(v, 65535); phase = ST_FRAMEMBS; end
      default: phase = ST_NALHDR;
    endcase
    return RES_NONE;
  endfunction

  function automatic void predict_byte(logic [7:0] b, bit last);
    res_t res;
    sps_fields_t r;
    res = RES_NONE;
    if (unit_done) begin
      if (last) unit_clear();
      return;
    end
    for (int i = 7; i >= 0 && res == RES_NONE; i--) res = bit_step(b[i]);
    if (res == RES_NONE && last) res = RES_BAD;
    if (res == RES_NONE) return;
    if (res == RES_BAD) group_reset(group_at(phase));
    r = fld;
    r.status = (res == RES_DONE) ? STATUS_OK : ((res == RES_BAD) ? STATUS_TRUNC : STATUS_LONG);
    sps_expected.push_back(r);
    if (last) unit_clear();
    else unit_done = 1;
  endfunction

  // ---------------- item driver ----------------
  function automatic int rand_gap();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_byte(logic [7:0] b, bit last, bit no_gap);
    int g;
    g = no_gap ? 0 : rand_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  // ---------------- unit builder ----------------
  bit nal_bits[$];
  int fidx, bad_at;

  function automatic void put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) nal_bits.push_back(v[i]);
  endfunction

  function automatic void put_ue(longint unsigned v);
    longint unsigned x;
    int n;
    if (fidx == bad_at) begin
      put_bits(0, 32);
      fidx++;
      return;
    end
    fidx++;
    x = v + 1; n = 0;
    while ((x >> (n + 1)) != 0) n++;
    put_bits(0, n);
    put_bits(x, n + 1);
  endfunction

  function automatic longint unsigned rnd_ue();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(7);
    if (p < 90) return $urandom_range(300);
    if (p < 98) return $urandom_range(70000);
    return $urandom_range(32'hFFFFFFFE);
  endfunction

  function automatic logic [7:0] rnd_profile();
    logic [7:0] hp[13] = '{PROF_HIGH, PROF_HIGH10, PROF_HIGH422, PROF_HIGH444,
      PROF_CAVLC444, PROF_SVC_B, PROF_SVC_H, PROF_MVC_H, PROF_STEREO, PROF_MFC_H,
      PROF_MFC_D, PROF_MVCD, PROF_MVCD_E};
    if ($urandom_range(1)) return hp[$urandom_range(12)];
    return 8'($urandom_range(255));
  endfunction

  // prof 0 picks at random; chroma/poct/cyc below zero pick at random
  function automatic void build_sps(logic [7:0] prof, int chroma, int poct, int cyc,
                                    bit scal, int bad);
    longint unsigned c, pt, nc, code;
    int lists, size, d, last, nxt;
    nal_bits.delete();
    fidx = 0; bad_at = bad;
    put_bits($urandom_range(255), 8);
    put_bits((prof == 0) ? rnd_profile() : prof, 8);
    put_bits($urandom_range(65535), 16);
    put_ue(rnd_ue());
    // decide the high branch from the profile actually written
    begin
      logic [7:0] pw;
      for (int i = 0; i < 8; i++) pw[7 - i] = nal_bits[8 + i];
      if (pw inside {PROF_HIGH, PROF_HIGH10, PROF_HIGH422, PROF_HIGH444,
          PROF_CAVLC444, PROF_SVC_B, PROF_SVC_H, PROF_MVC_H, PROF_STEREO,
          PROF_MFC_H, PROF_MFC_D, PROF_MVCD, PROF_MVCD_E}) begin
        c = (chroma >= 0) ? chroma : (($urandom_range(9) < 8) ? $urandom_range(3) : rnd_ue());
        put_ue(c);
        if (c == 3) put_bits($urandom_range(1), 1);
        put_ue(rnd_ue());
        put_ue(rnd_ue());
        put_bits($urandom_range(1), 1);
        put_bits(scal, 1);
        if (scal) begin
          lists = (c == 3) ? 12 : 8;
          for (int l = 0; l < lists; l++) begin
            if ($urandom_range(2) == 0) begin
              put_bits(0, 1);
              continue;
            end
            put_bits(1, 1);
            size = (l < 6) ? 16 : 64;
            last = 8;
            for (int j = 0; j < size; j++) begin
              if ($urandom_range(3) == 0) d = -last;
              else d = $urandom_range(255) - 128;
              code = (d > 0) ? 2 * d - 1 : -2 * d;
              put_ue(code);
              nxt = (last + d) & 255;
              if (nxt == 0) break;
              last = nxt;
            end
          end
        end
      end
    end
    put_ue(rnd_ue());
    pt = (poct >= 0) ? poct : (($urandom_range(9) < 9) ? $urandom_range(2) : rnd_ue());
    put_ue(pt);
    if (pt == 0) put_ue(rnd_ue());
    else if (pt == 1) begin
      put_bits($urandom_range(1), 1);
      put_ue(rnd_ue());
      put_ue(rnd_ue());
      nc = (cyc >= 0) ? cyc : (($urandom_range(9) < 8) ? $urandom_range(5) :
           $urandom_range(300, 250));
      put_ue(nc);
      if (nc <= 256) for (int k = 0; k < nc; k++) put_ue($urandom_range(20));
    end
    put_ue(rnd_ue());
    put_bits($urandom_range(1), 1);
    put_ue(rnd_ue());
    put_ue(rnd_ue());
    put_bits($urandom_range(1), 1);
    put_bits(1, 1);
    while (nal_bits.size() % 8 != 0) nal_bits.push_back(1'b0);
  endfunction

  // cut below zero keeps the whole unit
  task automatic send_unit(int cut, int junk);
    logic [7:0] bytes[$];
    logic [7:0] b;
    int n;
    for (int i = 0; i < nal_bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = nal_bits[i + k];
      bytes.push_back(b);
    end
    if (cut >= 0 && cut < bytes.size()) bytes = bytes[0:cut];
    repeat (junk) bytes.push_back(8'($urandom_range(255)));
    n = bytes.size();
    for (int i = 0; i < n; i++) send_byte(bytes[i], i == n - 1, 1'b0);
  endtask

  // input goes idle first so that the last byte is not offered again
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sps_expected.size() != 0) @(posedge clk);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    build_sps(8'd66, -1, 2, -1, 0, -1);          send_unit(-1, 0);
    build_sps(PROF_HIGH444, 3, 0, -1, 1, -1);    send_unit(-1, 2);
    build_sps(PROF_HIGH, 1, 1, 256, 0, -1);      send_unit(-1, 0);
    build_sps(PROF_HIGH, 1, 1, 257, 0, -1);      send_unit(-1, 1);
    build_sps(8'd77, -1, 0, -1, 0, 2);           send_unit(-1, 0);
    build_sps(PROF_MVCD_E, 300, 2, -1, 1, -1);   send_unit(-1, 0);
    build_sps(PROF_HIGH10, 0, 0, -1, 0, -1);     send_unit(3, 0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
  endtask

  task automatic test_random();
    int p;
    while (bytes_sent < 1950) begin
      p = $urandom_range(99);
      build_sps(0, -1, -1, -1, $urandom_range(3) == 0,
                ($urandom_range(9) == 0) ? $urandom_range(8) : -1);
      if (p < 75) send_unit(-1, ($urandom_range(3) == 0) ? $urandom_range(3) : 0);
      else if (p < 92) send_unit($urandom_range(nal_bits.size() / 8), 0);
      else repeat ($urandom_range(6, 1))
        send_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0);
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  task automatic test_backpressure();
    rx_long_hold = 1'b1;
    repeat (4) begin
      build_sps(0, -1, -1, -1, 0, -1);
      send_unit(-1, 0);
    end
    wait_drained();
  endtask

  initial begin
    unit_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------- result checking ----------------
  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  initial begin
    int hold;
    bit acc;
    sps_fields_t got, want;
    hold = 0;
    forever begin
      @(negedge clk);
      acc = out_tvalid && out_tready;
      got = sps_fields_t'(out_tdata[101:0]);
      @(posedge clk);
      if (acc) begin
        if (sps_expected.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = sps_expected.pop_front();
          check_field("status", want.status, got.status);
          check_field("profile", want.profile, got.profile);
          check_field("sps_id", want.sps_id, got.sps_id);
          check_field("chroma_format", want.chroma, got.chroma);
          check_field("bit_depth_luma", want.bd_luma, got.bd_luma);
          check_field("log2_max_frame_num_minus4", want.log2fn, got.log2fn);
          check_field("poc_type", want.poc_type, got.poc_type);
          check_field("log2_max_poc_lsb_minus4", want.poc_lsb, got.poc_lsb);
          check_field("max_num_ref_frames", want.max_ref, got.max_ref);
          check_field("pic_width_mbs_minus1", want.width, got.width);
          check_field("pic_height_units_minus1", want.height, got.height);
          check_field("frame_mbs_only", want.fmo, got.fmo);
        end
      end
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        hold = LONG_HOLD;
      end else if (hold == 0 && $urandom_range(99) < 20) begin
        hold = ($urandom_range(9) == 0) ? $urandom_range(50, 10) : $urandom_range(3, 1);
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------- end of run and watchdog ----------------
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(negedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int tail;
    tail = 0;
    while (!stim_done || sps_expected.size() != 0) @(posedge clk);
    while (tail < 60) begin
      @(posedge clk);
      tail++;
    end
    if (errors == 0 && sps_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (sps_expected.size() != 0) $error("%0d expected results never came", sps_expected.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
